>>> hw/rtl/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared types, register indexes and the character table of the Morse key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 16;
    localparam int INDEX_W     = 8;
    localparam int CODE_W      = 8;
    localparam int TABLE_LEN   = 29;
    localparam int TABLE_AW    = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_DASH_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_THRESHOLD  = 2'd1;

    localparam logic [COUNT_W-1:0] DASH_THRESHOLD_RESET = 16'd500;
    localparam logic [COUNT_W-1:0] GAP_THRESHOLD_RESET  = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX            = 16'hFFFF;
    localparam logic [INDEX_W-1:0] TREE_ROOT            = 8'd1;
    localparam logic [INDEX_W-1:0] TABLE_LAST           = 8'd29;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // fields from the lowest bit up: lamp_on, char_valid, char_code, char_unknown
    typedef struct packed {
        logic              char_unknown;
        logic [CODE_W-1:0] char_code;
        logic              char_valid;
        logic              lamp_on;
    } mkd_result_t;

    localparam int RESULT_W = $bits(mkd_result_t);

    localparam logic [CODE_W-1:0] LETTER_TABLE [0:TABLE_LEN-1] = '{
        8'h20, 8'h45, 8'h54, 8'h49, 8'h41, 8'h4E, 8'h4D, 8'h53, 8'h55, 8'h52,
        8'h57, 8'h44, 8'h4B, 8'h47, 8'h4F, 8'h48, 8'h56, 8'h46, 8'hDC, 8'h4C,
        8'hC4, 8'h50, 8'h4A, 8'h42, 8'h58, 8'h43, 8'h59, 8'h5A, 8'h51
    };

endpackage

>>> hw/rtl/mkd_core.sv
// ----------------------------------------------------------------------------
// mkd_core
// Threshold registers, key timing state and per-tick result computation.
// ----------------------------------------------------------------------------
module mkd_core import mkd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   tick_accept,
    input  logic                   key_pressed,
    output mkd_result_t            result
);

    logic [COUNT_W-1:0] dash_threshold_reg;
    logic [COUNT_W-1:0] gap_threshold_reg;
    logic [COUNT_W-1:0] hold_count_reg, hold_count_next;
    logic [COUNT_W-1:0] gap_count_reg, gap_count_next;
    logic               was_pressed_reg, was_pressed_next;
    logic [INDEX_W-1:0] tree_index_reg, tree_index_next;
    logic               lamp_reg, lamp_next;
    logic [INDEX_W-1:0] table_offset;
    logic               in_table;
    logic               is_dash;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dash_threshold_reg <= DASH_THRESHOLD_RESET;
            gap_threshold_reg  <= GAP_THRESHOLD_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_DASH_THRESHOLD) begin
                dash_threshold_reg <= cfg_wdata;
            end
            if (cfg_index == REG_GAP_THRESHOLD) begin
                gap_threshold_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_count_reg  <= '0;
            gap_count_reg   <= '0;
            was_pressed_reg <= 1'b0;
            tree_index_reg  <= TREE_ROOT;
            lamp_reg        <= 1'b0;
        end else if (tick_accept) begin
            hold_count_reg  <= hold_count_next;
            gap_count_reg   <= gap_count_next;
            was_pressed_reg <= was_pressed_next;
            tree_index_reg  <= tree_index_next;
            lamp_reg        <= lamp_next;
        end
    end

    assign table_offset = tree_index_reg - TREE_ROOT;
    assign in_table     = (tree_index_reg >= TREE_ROOT) && (tree_index_reg <= TABLE_LAST);
    assign is_dash      = (hold_count_reg >= dash_threshold_reg);

    always_comb begin
        hold_count_next     = hold_count_reg;
        gap_count_next      = gap_count_reg;
        was_pressed_next    = was_pressed_reg;
        tree_index_next     = tree_index_reg;
        lamp_next           = lamp_reg;
        result              = '0;
        if (key_pressed) begin
            if (hold_count_reg != COUNT_MAX) begin
                hold_count_next = hold_count_reg + COUNT_W'(1);
            end
            if (hold_count_next >= dash_threshold_reg) begin
                lamp_next = 1'b1;
            end
            was_pressed_next = 1'b1;
            gap_count_next   = '0;
        end else if (was_pressed_reg) begin
            // step down the tree: left for a dot, right for a dash
            tree_index_next  = {tree_index_reg[INDEX_W-2:0], is_dash};
            was_pressed_next = 1'b0;
            hold_count_next  = '0;
            lamp_next        = 1'b0;
        end else if (gap_count_reg >= gap_threshold_reg) begin
            result.char_valid = 1'b1;
            if (in_table) begin
                result.char_code = LETTER_TABLE[table_offset[TABLE_AW-1:0]];
            end else begin
                result.char_unknown = 1'b1;
            end
            tree_index_next = TREE_ROOT;
            gap_count_next  = '0;
        end else begin
            gap_count_next = gap_count_reg + COUNT_W'(1);
        end
        result.lamp_on = lamp_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_accept && result.char_valid) |=> (tree_index_reg == TREE_ROOT))
        else $error("tree index not returned to root after emission");

    assert property (@(posedge aclk) disable iff (!aresetn)
        lamp_reg |-> was_pressed_reg)
        else $error("lamp lit without a held key");

    assert property (@(posedge aclk) disable iff (!aresetn)
        result.char_unknown |-> (result.char_valid && (result.char_code == '0)))
        else $error("unknown character with code or without valid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_accept && key_pressed) |=> (gap_count_reg == '0))
        else $error("gap count not cleared while key held");
`endif

endmodule

>>> hw/rtl/mkd_out_buf.sv
// ----------------------------------------------------------------------------
// mkd_out_buf
// Two-entry output register with skid stage for the result stream.
// ----------------------------------------------------------------------------
module mkd_out_buf import mkd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  mkd_result_t push_data,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output mkd_result_t out_data
);

    logic        main_valid_reg;
    logic        skid_valid_reg;
    mkd_result_t main_data_reg;
    mkd_result_t skid_data_reg;
    logic        pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry occupied with main entry empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !out_ready && push) |=> skid_valid_reg)
        else $error("transaction pushed into a full output not kept in skid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output");
`endif

endmodule

>>> hw/rtl/morse_key_decoder.sv
// ----------------------------------------------------------------------------
// morse_key_decoder
// Morse key decoder: timed key presses walk a binary tree to a character.
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying the sampled key level and
// produces exactly one result transaction: the lamp level, and when the gap
// after the last element has reached gap_threshold idle ticks, the decoded
// Latin-1 character (a space when no elements were keyed, unknown flag set
// for codes outside the table). The block takes one tick per clock cycle;
// the key timing state is registered on each accepted tick and results leave through
// a two-entry output register, so input stalls only once two results are
// waiting on the output. Thresholds are written through the cfg port
// (index 0 dash_threshold, index 1 gap_threshold) while the stream is idle.
module morse_key_decoder import mkd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // key_pressed
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // lamp_on, char_valid, char_code, char_unknown
);

    logic        tick_accept;
    mkd_result_t core_result;
    mkd_result_t out_result;

    assign tick_accept = s_tvalid && s_tready;

    mkd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .tick_accept (tick_accept),
        .key_pressed (s_tdata[0]),
        .result      (core_result)
    );

    mkd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (tick_accept),
        .push_data  (core_result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_result)
    );

    assign m_tdata = {{(OUT_DATA_W-RESULT_W){1'b0}}, out_result};

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the Morse key decoder.
// ----------------------------------------------------------------------------
// Key ticks are streamed into the decoder. A scoreboard class decodes each
// accepted tick on its own copy of the counters and the tree index, then
// compares every result transaction field by field in order. The run first
// checks a short press and gap under the reset thresholds and a set of
// directed codes: umlauts, the last table entry, indexes off the table and
// the wrapped index, zero and one thresholds, and a threshold lowered
// mid-gap. It then streams random well-formed characters mixed with noise
// under three flow-control mixes.
// ----------------------------------------------------------------------------
module tb;
    import mkd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int END_SETTLE     = 10;
    localparam int PHASE_TICKS    = 150;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_OF_RANGE = 2'd3;

    class morse_scoreboard;
        logic [COUNT_W-1:0] dash_limit;
        logic [COUNT_W-1:0] gap_limit;
        logic [COUNT_W-1:0] hold_cnt;
        logic [COUNT_W-1:0] gap_cnt;
        logic               key_held;
        logic [INDEX_W-1:0] node;
        logic               lamp;
        mkd_result_t        pending_results[$];
        int mismatches;
        int results_seen;
        int ticks;
        int chars;
        int unknowns;
        int spaces;
        int lamp_ticks;

        function new();
            dash_limit = 16'd500;
            gap_limit  = 16'd1000;
            hold_cnt = '0;
            gap_cnt  = '0;
            key_held = 1'b0;
            node     = 8'd1;
            lamp     = 1'b0;
            mismatches = 0;
            results_seen = 0;
            ticks = 0;
            chars = 0;
            unknowns = 0;
            spaces = 0;
            lamp_ticks = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DASH_THRESHOLD: dash_limit = val;
                REG_GAP_THRESHOLD:  gap_limit  = val;
                default: ;
            endcase
        endfunction

        function logic [CODE_W-1:0] letter_at(logic [INDEX_W-1:0] n);
            case (n)
                8'd1:  return 8'h20;
                8'd2:  return "E";
                8'd3:  return "T";
                8'd4:  return "I";
                8'd5:  return "A";
                8'd6:  return "N";
                8'd7:  return "M";
                8'd8:  return "S";
                8'd9:  return "U";
                8'd10: return "R";
                8'd11: return "W";
                8'd12: return "D";
                8'd13: return "K";
                8'd14: return "G";
                8'd15: return "O";
                8'd16: return "H";
                8'd17: return "V";
                8'd18: return "F";
                8'd19: return 8'hDC;
                8'd20: return "L";
                8'd21: return 8'hC4;
                8'd22: return "P";
                8'd23: return "J";
                8'd24: return "B";
                8'd25: return "X";
                8'd26: return "C";
                8'd27: return "Y";
                8'd28: return "Z";
                8'd29: return "Q";
                default: return '0;
            endcase
        endfunction

        function void decode_tick(logic key);
            mkd_result_t r;
            r = '0;
            ticks++;
            if (key) begin
                if (hold_cnt != COUNT_MAX) hold_cnt = hold_cnt + COUNT_W'(1);
                if (hold_cnt >= dash_limit) lamp = 1'b1;
                key_held = 1'b1;
                gap_cnt = '0;
            end else if (key_held) begin
                node = {node[INDEX_W-2:0], hold_cnt >= dash_limit};
                key_held = 1'b0;
                hold_cnt = '0;
                lamp = 1'b0;
            end else if (gap_cnt >= gap_limit) begin
                r.char_valid = 1'b1;
                chars++;
                if (node >= 8'd1 && node <= 8'(TABLE_LEN)) begin
                    r.char_code = letter_at(node);
                    if (node == 8'd1) spaces++;
                end else begin
                    r.char_unknown = 1'b1;
                    unknowns++;
                end
                node = 8'd1;
                gap_cnt = '0;
            end else begin
                gap_cnt = gap_cnt + COUNT_W'(1);
            end
            r.lamp_on = lamp;
            if (lamp) lamp_ticks++;
            pending_results.push_back(r);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] tdata);
            mkd_result_t got;
            mkd_result_t want;
            got = tdata[RESULT_W-1:0];
            if (pending_results.size() == 0) begin
                report($sformatf("result %h arrived with no tick waiting", tdata));
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            if (got.lamp_on !== want.lamp_on)
                report($sformatf("result %0d lamp_on got %b expected %b",
                                 results_seen, got.lamp_on, want.lamp_on));
            if (got.char_valid !== want.char_valid)
                report($sformatf("result %0d char_valid got %b expected %b",
                                 results_seen, got.char_valid, want.char_valid));
            if (got.char_code !== want.char_code)
                report($sformatf("result %0d char_code got %h expected %h",
                                 results_seen, got.char_code, want.char_code));
            if (got.char_unknown !== want.char_unknown)
                report($sformatf("result %0d char_unknown got %b expected %b",
                                 results_seen, got.char_unknown, want.char_unknown));
            if (tdata[OUT_DATA_W-1:RESULT_W] !== '0)
                report($sformatf("result %0d padding bits not zero: %h", results_seen, tdata));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;   // key_pressed
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;   // lamp_on, char_valid, char_code, char_unknown

    morse_scoreboard sb;
    int tx_idle_pct = 38;
    int rx_idle_pct = 64;
    int rx_hold_req = 0;
    int ticks_sent = 0;
    int cur_dash = 500;
    int cur_gap = 1000;
    int stuck_cycles = 0;

    morse_key_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // result check and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // result side ready, with an occasional long hold-off
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req != 0) begin
                rx_hold_req = 0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_tick(input logic key);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(key);
        do @(posedge aclk); while (!s_tready);
        sb.decode_tick(key);
        ticks_sent++;
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) send_tick(1'b0);
    endtask

    task automatic key_element(input int hold);
        repeat (hold) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // dots held one tick, dashes held the dash threshold, then a full gap
    task automatic send_code(input string pattern);
        for (int i = 0; i < pattern.len(); i++) begin
            if (pattern[i] == "-") key_element((cur_dash > 1) ? cur_dash : 1);
            else key_element(1);
        end
        idle_ticks(cur_gap + 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_thresholds(input int dash, input int gap);
        cfg_write(REG_DASH_THRESHOLD, CFG_DATA_W'(dash));
        cfg_write(REG_GAP_THRESHOLD, CFG_DATA_W'(gap));
        cur_dash = dash;
        cur_gap = gap;
    endtask

    task automatic randomize_thresholds();
        int dash;
        int gap;
        dash = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
        gap  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        set_thresholds(dash, gap);
    endtask

    task automatic random_char();
        int kind;
        int n_el;
        int hold;
        int lo;
        kind = $urandom_range(0, 99);
        lo = (cur_dash > 1) ? cur_dash : 1;
        if (kind < 12) begin
            repeat ($urandom_range(4, 16)) send_tick(1'($urandom_range(0, 1)));
        end else begin
            n_el = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
            repeat (n_el) begin
                if (cur_dash > 1 && $urandom_range(0, 1) == 1) hold = $urandom_range(1, cur_dash - 1);
                else hold = $urandom_range(lo, lo + 2);
                key_element(hold);
                idle_ticks($urandom_range(0, cur_gap));
            end
            // broken characters stop short of the closing gap
            if (kind < 20) idle_ticks($urandom_range(0, cur_gap));
            else idle_ticks(cur_gap + 1 + $urandom_range(0, 2));
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct);
        int start;
        int since_cfg;
        wait_drained();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        randomize_thresholds();
        start = ticks_sent;
        since_cfg = ticks_sent;
        rx_hold_req = 1;
        random_char();
        wait_drained();
        while (ticks_sent - start < PHASE_TICKS) begin
            random_char();
            if (ticks_sent - since_cfg > 70) begin
                randomize_thresholds();
                since_cfg = ticks_sent;
            end else if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DASH_THRESHOLD;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // short press and gap under the reset thresholds
        key_element(4);
        idle_ticks(6);

        // directed codes
        cfg_write(REG_OUT_OF_RANGE, 16'hFFFF);
        set_thresholds(3, 2);
        send_code("");
        send_code("..--");
        send_code(".-.-");
        send_code("--.-");
        send_code("---.");
        send_code("........");
        send_code("-----");
        set_thresholds(3, 0);
        idle_ticks(3);
        set_thresholds(0, 2);
        send_code(".");
        set_thresholds(1, 2);
        send_code("..");
        // gap threshold lowered while a gap is under way
        set_thresholds(3, 65535);
        key_element(1);
        key_element(3);
        idle_ticks(10);
        set_thresholds(3, 2);
        idle_ticks(1);
        idle_ticks(3);

        random_phase(38, 64);
        random_phase(64, 38);
        random_phase(0, 0);

        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d key ticks and %0d results: %0d characters, %0d spaces, %0d unknown",
                 sb.ticks, sb.results_seen, sb.chars, sb.spaces, sb.unknowns);
        $display("lamp lit on %0d ticks; thresholds 0 to 65535, ignored index, three stall mixes",
                 sb.lamp_ticks);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_core.sv
hw/rtl/mkd_out_buf.sv
hw/rtl/morse_key_decoder.sv
tb/sv/tb.sv
